>>> design/bif_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bif_pkg
// Shared types and constants of the binary image border follower: sequencer
// states, result status codes, request codes and the 8-neighbour offsets.
// ----------------------------------------------------------------------------
package bif_pkg;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_SRCH  = 5'b00100,
    ST_TRACE = 5'b01000,
    ST_OUT   = 5'b10000
  } bif_state_t;

  // result status codes
  localparam logic [1:0] STAT_BORDER = 2'd0;
  localparam logic [1:0] STAT_NOOUT  = 2'd1;
  localparam logic [1:0] STAT_DONE   = 2'd2;
  localparam logic [1:0] STAT_OVF    = 2'd3;

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // directions, clockwise from north, row grows downward
  localparam logic [2:0] DIR_EAST = 3'd2;
  localparam logic [2:0] DIR_WEST = 3'd6;

  function automatic logic signed [1:0] dir_drow(input logic [2:0] d);
    logic signed [1:0] v;
    case (d)
      3'd0, 3'd1, 3'd7: v = -2'sd1;
      3'd3, 3'd4, 3'd5: v = 2'sd1;
      default:          v = 2'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [1:0] dir_dcol(input logic [2:0] d);
    logic signed [1:0] v;
    case (d)
      3'd1, 3'd2, 3'd3: v = 2'sd1;
      3'd5, 3'd6, 3'd7: v = -2'sd1;
      default:          v = 2'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> design/bif_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bif_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module bif_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/binary_image_border_follower.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_image_border_follower
// Raster scan with border following over a binary image held in a label RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): a load transfer writes one pixel into
//   the label RAM and restarts the scan; it gives no result. A step
//   transfer does one visit and gives exactly one result on the output
//   channel (out_valid/out_ready).
//   Every neighbour lookup has an address phase, then a RAM data phase, as
//   the single label RAM read port serves one pixel per lookup. A scan
//   visit reads center, west and east; a new border adds up to 8 searched
//   neighbours plus the first trace visit; a trace visit reads its own
//   label and up to 8 neighbours.
//   One step is in flight at a time; in_ready is high only when idle.
//   A finished result waits in the output register while the next item may
//   be taken; if the receiver stalls, the next result waits in its state.
//   Reset clears the scan, tracing and overflow state and sets both size
//   registers to 64; the label RAM is not cleared and must be
//   loaded before it is scanned. Register writes over APB restart the scan.
// ----------------------------------------------------------------------------
module binary_image_border_follower
  import bif_pkg::*;
#(
  parameter int MAX_WIDTH   = 64,
  parameter int MAX_HEIGHT  = 64,
  parameter int MAX_BORDERS = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [5:0]  in_pixel_row,
  input  logic [5:0]  in_pixel_col,
  input  logic        in_pixel_value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_step_status,
  output logic [5:0]  out_border_row,
  output logic [5:0]  out_border_col,
  output logic [7:0]  out_border_number,
  output logic        out_hole_mark,
  output logic        out_last_of_border,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CPW   = $clog2(MAX_WIDTH + 1);
  localparam int RPW   = $clog2(MAX_HEIGHT + 1);
  localparam int BW    = $clog2(MAX_BORDERS + 1);
  localparam int LW    = BW + 1;

  bif_state_t state_r;

  // configuration and scan state
  logic [6:0]     width_r, height_r;
  logic [RPW-1:0] scan_row_r, start_row_r, second_row_r, cur_row_r;
  logic [CW-1:0]  scan_col_r, start_col_r, second_col_r, cur_col_r;
  logic [BW-1:0]  bc_r;
  logic           tracing_r, ovf_r, hole_r;
  logic [2:0]     pdir_r, sd_r;
  logic [3:0]     k_r;
  logic           phase_r, inb_r;
  logic signed [LW-1:0] f_r, cv_r;
  logic           wz_r, ez_r;

  // pending result
  logic [1:0] res_status_r;
  logic [5:0] res_row_r, res_col_r;
  logic [7:0] res_num_r;
  logic       res_hole_r, res_last_r;

  // output register
  logic       out_valid_r;
  logic [1:0] out_status_r;
  logic [5:0] out_row_r, out_col_r;
  logic [7:0] out_num_r;
  logic       out_hole_r, out_last_r;

  // clamped image size
  logic [31:0]    uw32, uh32;
  logic [CPW-1:0] uw;
  logic [RPW-1:0] uh;

  always_comb begin
    uw32 = 32'(width_r);
    if (uw32 < 32'd3) uw32 = 32'd3;
    if (uw32 > 32'(MAX_WIDTH)) uw32 = 32'(MAX_WIDTH);
    uh32 = 32'(height_r);
    if (uh32 < 32'd1) uh32 = 32'd1;
    if (uh32 > 32'(MAX_HEIGHT)) uh32 = 32'(MAX_HEIGHT);
    uw = CPW'(uw32);
    uh = RPW'(uh32);
  end

  // next scan position
  logic [RPW-1:0] adv_row;
  logic [CW-1:0]  adv_col;

  always_comb begin
    if ((CPW'(scan_col_r) + CPW'(1)) >= uw) begin
      adv_col = '0;
      adv_row = scan_row_r + RPW'(1);
    end else begin
      adv_col = scan_col_r + CW'(1);
      adv_row = scan_row_r;
    end
  end

  // neighbour lookup: base pixel plus direction
  logic [RPW-1:0]          base_row;
  logic [CW-1:0]           base_col;
  logic [2:0]              q_dir;
  logic                    q_self;
  logic signed [RPW:0]     nr;
  logic signed [CW+1:0]    nc;
  logic                    q_inb;
  logic [AW-1:0]           q_addr, self_addr;

  always_comb begin
    base_row = scan_row_r;
    base_col = scan_col_r;
    q_dir    = '0;
    q_self   = 1'b0;
    unique case (state_r)
      ST_SCAN: begin
        q_self = (k_r == 4'd0);
        q_dir  = (k_r == 4'd1) ? DIR_WEST : DIR_EAST;
      end
      ST_SRCH: begin
        q_dir = sd_r + k_r[2:0];
      end
      ST_TRACE: begin
        base_row = cur_row_r;
        base_col = cur_col_r;
        q_self   = (k_r == 4'd0);
        q_dir    = pdir_r - k_r[2:0];
      end
      default: begin
        q_self = 1'b1;
      end
    endcase
    if (q_self) begin
      nr = $signed({1'b0, base_row});
      nc = $signed({2'b00, base_col});
    end else begin
      nr = $signed({1'b0, base_row}) + (RPW+1)'(dir_drow(q_dir));
      nc = $signed({2'b00, base_col}) + (CW+2)'(dir_dcol(q_dir));
    end
    q_inb = !nr[RPW] && (nr[RPW-1:0] < uh) &&
            !nc[CW+1] && (nc[CW:0] < (CW+1)'(uw));
    q_addr    = AW'(32'(nr[RPW-1:0]) * MAX_WIDTH + 32'(nc[CW-1:0]));
    self_addr = AW'(32'(base_row) * MAX_WIDTH + 32'(base_col));
  end

  // label RAM
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [LW-1:0]        ram_wdata;
  logic [LW-1:0]        ram_rdata;
  logic signed [LW-1:0] qv;
  logic                 qnz;

  assign qv  = inb_r ? $signed(ram_rdata) : '0;
  assign qnz = (qv != '0);

  bif_ram #(
    .WIDTH (LW),
    .DEPTH (DEPTH)
  ) u_label_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (q_addr),
    .rd_data (ram_rdata)
  );

  // handshakes
  logic in_xfer, load_xfer, step_xfer, cfg_wr;
  logic load_inrange;

  assign in_ready     = (state_r == ST_IDLE);
  assign in_xfer      = in_valid && in_ready;
  assign load_xfer    = in_xfer && (in_req_type == REQ_LOAD);
  assign step_xfer    = in_xfer && (in_req_type == REQ_STEP);
  assign cfg_wr       = psel && penable && pwrite;
  assign load_inrange = (32'(in_pixel_row) < 32'(MAX_HEIGHT)) &&
                        (32'(in_pixel_col) < 32'(MAX_WIDTH));

  // decisions of the evaluate cycles
  logic                 trace_done, ezn, trace_last;
  logic signed [LW-1:0] nbd;
  logic                 n_is_start, cur_is_second;

  assign nbd           = $signed({1'b0, bc_r});
  assign trace_done    = qnz || (k_r == 4'd8);
  assign ezn           = ez_r || (!qnz && (q_dir == DIR_EAST));
  assign n_is_start    = (nr[RPW-1:0] == start_row_r) && (nc[CW-1:0] == start_col_r);
  assign cur_is_second = (cur_row_r == second_row_r) && (cur_col_r == second_col_r);
  assign trace_last    = !qnz || (n_is_start && cur_is_second);

  // label writes: pixel loads, lonely pixels and trace relabels
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = self_addr;
    ram_wdata = '0;
    if (load_xfer && load_inrange) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(32'(in_pixel_row) * MAX_WIDTH + 32'(in_pixel_col));
      ram_wdata = LW'(in_pixel_value);
    end else if (state_r == ST_SRCH && phase_r && !qnz && k_r == 4'd7) begin
      ram_we    = 1'b1;
      ram_wdata = -nbd;
    end else if (state_r == ST_TRACE && phase_r && k_r != 4'd0 && trace_done) begin
      if (ezn) begin
        ram_we    = 1'b1;
        ram_wdata = -nbd;
      end else if (cv_r == LW'(1)) begin
        ram_we    = 1'b1;
        ram_wdata = nbd;
      end
    end
  end

  // outer / hole start tests at the end of a scan visit
  logic is_outer, is_hole;

  assign is_outer = (f_r == LW'(1)) && wz_r;
  assign is_hole  = !is_outer && (f_r > 0) && !qnz;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= 7'd64;
      height_r    <= 7'd64;
      scan_row_r  <= '0;
      scan_col_r  <= '0;
      bc_r        <= BW'(1);
      tracing_r   <= 1'b0;
      ovf_r       <= 1'b0;
      hole_r      <= 1'b0;
      start_row_r <= '0;
      start_col_r <= '0;
      second_row_r <= '0;
      second_col_r <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      pdir_r      <= '0;
      k_r         <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // the output register is refilled in ST_OUT
      if (out_valid_r && out_ready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      // register writes and pixel loads restart the scan
      if (cfg_wr || load_xfer) begin
        if (cfg_wr) begin
          if (paddr[2] == REG_WIDTH) width_r <= pwdata[6:0];
          else                       height_r <= pwdata[6:0];
        end
        scan_row_r <= '0;
        scan_col_r <= '0;
        bc_r       <= BW'(1);
        tracing_r  <= 1'b0;
        ovf_r      <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (step_xfer) begin
            res_status_r <= STAT_NOOUT;
            res_row_r    <= '0;
            res_col_r    <= '0;
            res_num_r    <= '0;
            res_hole_r   <= 1'b0;
            res_last_r   <= 1'b0;
            k_r          <= '0;
            phase_r      <= 1'b0;
            if (tracing_r) begin
              state_r <= ST_TRACE;
            end else if (ovf_r) begin
              res_status_r <= STAT_OVF;
              state_r      <= ST_OUT;
            end else if (scan_row_r >= uh) begin
              res_status_r <= STAT_DONE;
              state_r      <= ST_OUT;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end

        // center, west, east of the scan pixel
        ST_SCAN: begin
          phase_r <= !phase_r;
          inb_r   <= q_inb;
          if (phase_r) begin
            if (k_r == 4'd0) begin
              f_r <= qv;
              k_r <= k_r + 4'd1;
            end else if (k_r == 4'd1) begin
              wz_r <= !qnz;
              k_r  <= k_r + 4'd1;
            end else begin
              if (!is_outer && !is_hole) begin
                scan_row_r <= adv_row;
                scan_col_r <= adv_col;
                state_r    <= ST_OUT;
              end else if (32'(bc_r) >= 32'(MAX_BORDERS)) begin
                ovf_r        <= 1'b1;
                res_status_r <= STAT_OVF;
                state_r      <= ST_OUT;
              end else begin
                bc_r    <= bc_r + BW'(1);
                hole_r  <= is_hole;
                sd_r    <= is_hole ? DIR_EAST : DIR_WEST;
                k_r     <= '0;
                state_r <= ST_SRCH;
              end
            end
          end
        end

        // clockwise search for the first nonzero neighbour of a new border
        ST_SRCH: begin
          phase_r <= !phase_r;
          inb_r   <= q_inb;
          if (phase_r) begin
            if (qnz) begin
              start_row_r  <= scan_row_r;
              start_col_r  <= scan_col_r;
              second_row_r <= nr[RPW-1:0];
              second_col_r <= nc[CW-1:0];
              cur_row_r    <= scan_row_r;
              cur_col_r    <= scan_col_r;
              pdir_r       <= q_dir;
              tracing_r    <= 1'b1;
              k_r          <= '0;
              state_r      <= ST_TRACE;
            end else if (k_r == 4'd7) begin
              // lonely pixel: one-pixel border
              res_status_r <= STAT_BORDER;
              res_row_r    <= 6'(scan_row_r);
              res_col_r    <= 6'(scan_col_r);
              res_num_r    <= 8'(bc_r);
              res_hole_r   <= hole_r;
              res_last_r   <= 1'b1;
              scan_row_r   <= adv_row;
              scan_col_r   <= adv_col;
              state_r      <= ST_OUT;
            end else begin
              k_r <= k_r + 4'd1;
            end
          end
        end

        // one trace visit: own label, then counterclockwise search
        ST_TRACE: begin
          phase_r <= !phase_r;
          inb_r   <= q_inb;
          if (phase_r) begin
            if (k_r == 4'd0) begin
              cv_r <= qv;
              ez_r <= 1'b0;
              k_r  <= 4'd1;
            end else begin
              ez_r <= ezn;
              if (!trace_done) begin
                k_r <= k_r + 4'd1;
              end else begin
                res_status_r <= STAT_BORDER;
                res_row_r    <= 6'(cur_row_r);
                res_col_r    <= 6'(cur_col_r);
                res_num_r    <= 8'(bc_r);
                res_hole_r   <= hole_r;
                res_last_r   <= trace_last;
                if (trace_last) begin
                  tracing_r  <= 1'b0;
                  scan_row_r <= adv_row;
                  scan_col_r <= adv_col;
                end else begin
                  pdir_r    <= q_dir + 3'd4;
                  cur_row_r <= nr[RPW-1:0];
                  cur_col_r <= nc[CW-1:0];
                end
                state_r <= ST_OUT;
              end
            end
          end
        end

        // hand the result to the output register
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_row_r    <= res_row_r;
            out_col_r    <= res_col_r;
            out_num_r    <= res_num_r;
            out_hole_r   <= res_hole_r;
            out_last_r   <= res_last_r;
            state_r      <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // outputs
  assign out_valid          = out_valid_r;
  assign out_step_status    = out_status_r;
  assign out_border_row     = out_row_r;
  assign out_border_col     = out_col_r;
  assign out_border_number  = out_num_r;
  assign out_hole_mark      = out_hole_r;
  assign out_last_of_border = out_last_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_r) : 32'(width_r);

endmodule
